### design/dda_pkg.sv
package dda_pkg;

   localparam int DISK_SIDES_DEF = 4;
   localparam int SIDE_BITS      = 16;

   // request kinds
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;
   localparam logic [1:0] MODE_LOAD  = 2'd3;

   // register offsets
   localparam logic [11:0] REG_TIMER_LO  = 12'h020;
   localparam logic [11:0] REG_TIMER_HI  = 12'h021;
   localparam logic [11:0] REG_TIMER_CTL = 12'h022;
   localparam logic [11:0] REG_IO_EN     = 12'h023;
   localparam logic [11:0] REG_WR_DATA   = 12'h024;
   localparam logic [11:0] REG_DRIVE_CTL = 12'h025;
   localparam logic [11:0] REG_STATUS    = 12'h030;
   localparam logic [11:0] REG_RD_DATA   = 12'h031;
   localparam logic [11:0] REG_DRIVE_ST  = 12'h032;
   localparam logic [11:0] REG_FIXED     = 12'h033;

   // configuration register indexes
   localparam logic CSR_DISK_PRESENT = 1'b0;
   localparam logic CSR_DISK_SIDE    = 1'b1;

   localparam logic [15:0] PTR_READ_MAX    = 16'd64999;
   localparam logic [15:0] PTR_WRITE_LIMIT = 16'd65000;
   localparam logic [7:0]  DELAY_SHORT     = 8'd150;
   localparam logic [7:0]  DELAY_LONG      = 8'd200;
   localparam logic [7:0]  ST_BASE         = 8'h40;
   localparam logic [7:0]  ST_NO_DISK      = 8'h05;
   localparam logic [7:0]  ST_NOT_READY    = 8'h02;
   localparam logic [7:0]  FIXED_BYTE      = 8'h80;

   localparam int FLAG_TIMER = 0;
   localparam int FLAG_DISK  = 1;

   typedef enum logic [1:0] {
      RD_IMM,
      RD_DISK,
      RD_LAST
   } rd_sel_type;

   // what the response stage needs to finish one request
   typedef struct packed {
      logic       handled;
      rd_sel_type sel;
      logic [7:0] imm;
      logic       side_ok;
      logic       irq;
      logic       mirror;
   } stage_info_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

### design/dda_image_ram.sv
module dda_image_ram #(
   parameter int DISK_SIDES = dda_pkg::DISK_SIDES_DEF,
   parameter int AW         = $clog2(DISK_SIDES) + dda_pkg::SIDE_BITS
) (
   input  logic                  clock,
   input  dda_pkg::mem_ctl_type  mem_ctl,
   input  logic [AW-1:0]         mem_addr,
   input  logic [7:0]            mem_wdata,
   output logic [7:0]            mem_rdata
);

   localparam int DEPTH = DISK_SIDES * (2 ** dda_pkg::SIDE_BITS);

   logic [7:0] image_mem [0:DEPTH-1];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         image_mem[mem_addr] <= mem_wdata;
      end
      if (mem_ctl.rd_en) begin
         rdata_ff <= image_mem[mem_addr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

### design/dda_ctrl.sv
module dda_ctrl #(
   parameter int DISK_SIDES = dda_pkg::DISK_SIDES_DEF,
   parameter int AW         = $clog2(DISK_SIDES) + dda_pkg::SIDE_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [1:0]              mode,
   input  logic [11:0]             address,
   input  logic [7:0]              write_data,
   input  logic [17:0]             image_index,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [1:0]              csr_wdata,
   output dda_pkg::mem_ctl_type    mem_ctl,
   output logic [AW-1:0]           mem_addr,
   output logic [7:0]              mem_wdata,
   output dda_pkg::stage_info_type info
);

   localparam int STORE = DISK_SIDES * (2 ** dda_pkg::SIDE_BITS);

   logic        present_ff;
   logic [1:0]  side_ff;
   logic [15:0] tcount_ff, tcount_in;
   logic [15:0] treload_ff, treload_in;
   logic [1:0]  tmode_ff, tmode_in;
   logic [7:0]  io_en_ff, io_en_in;
   logic [7:0]  dctl_ff, dctl_in;
   logic [1:0]  flags_ff, flags_in;
   logic [15:0] ptr_ff, ptr_in;
   logic [1:0]  skip_ff, skip_in;
   logic [7:0]  delay_ff, delay_in;
   logic        mirror_ff, mirror_in;

   logic        side_ok;
   logic        load_ok;
   logic [31:0] rd_full;
   logic [31:0] wr_full;
   logic [31:0] ld_full;
   logic [15:0] ptr_back;

   assign side_ok  = (32'(side_ff) < DISK_SIDES);
   assign load_ok  = (32'(image_index) < STORE);
   assign ptr_back = ptr_ff - 16'd2;
   assign rd_full  = {14'd0, side_ff, ptr_ff};
   assign wr_full  = {14'd0, side_ff, ptr_back};
   assign ld_full  = {14'd0, image_index};

   always_comb begin
      tcount_in  = tcount_ff;
      treload_in = treload_ff;
      tmode_in   = tmode_ff;
      io_en_in   = io_en_ff;
      dctl_in    = dctl_ff;
      flags_in   = flags_ff;
      ptr_in     = ptr_ff;
      skip_in    = skip_ff;
      delay_in   = delay_ff;
      mirror_in  = mirror_ff;
      mem_ctl    = '0;
      mem_addr   = rd_full[AW-1:0];
      mem_wdata  = write_data;
      info.handled = 1'b0;
      info.sel     = dda_pkg::RD_IMM;
      info.imm     = 8'd0;
      info.side_ok = side_ok;

      if (accept) begin
         case (mode)
            dda_pkg::MODE_TICK: begin
               if (tmode_ff[1] && tcount_ff != 16'd0) begin
                  tcount_in = tcount_ff - 16'd1;
                  if (tcount_ff == 16'd1) begin
                     if (tmode_ff[0]) begin
                        tcount_in = treload_ff;
                     end else begin
                        tmode_in = {1'b0, tmode_ff[0]};
                     end
                     flags_in[dda_pkg::FLAG_TIMER] = 1'b1;
                  end
               end
               if (delay_ff != 8'd0) begin
                  delay_in = delay_ff - 8'd1;
                  if (delay_ff == 8'd1 && dctl_ff[7]) begin
                     flags_in[dda_pkg::FLAG_DISK] = 1'b1;
                  end
               end
            end
            dda_pkg::MODE_READ: begin
               case (address)
                  dda_pkg::REG_STATUS: begin
                     info.handled = 1'b1;
                     info.imm     = {6'd0, flags_ff};
                     flags_in     = 2'b00;
                  end
                  dda_pkg::REG_RD_DATA: begin
                     info.handled = 1'b1;
                     if (!present_ff) begin
                        info.sel = dda_pkg::RD_LAST;
                     end else begin
                        info.sel       = dda_pkg::RD_DISK;
                        mem_ctl.rd_en  = 1'b1;
                        if (ptr_ff < dda_pkg::PTR_READ_MAX) begin
                           ptr_in = ptr_ff + 16'd1;
                        end
                        delay_in = dda_pkg::DELAY_SHORT;
                        flags_in[dda_pkg::FLAG_DISK] = 1'b0;
                     end
                  end
                  dda_pkg::REG_DRIVE_ST: begin
                     info.handled = 1'b1;
                     info.imm     = dda_pkg::ST_BASE;
                     if (!present_ff) begin
                        info.imm = info.imm | dda_pkg::ST_NO_DISK;
                     end
                     if (!present_ff || !dctl_ff[0] || dctl_ff[1]) begin
                        info.imm = info.imm | dda_pkg::ST_NOT_READY;
                     end
                  end
                  dda_pkg::REG_FIXED: begin
                     info.handled = 1'b1;
                     info.imm     = dda_pkg::FIXED_BYTE;
                  end
                  default: begin
                     info.handled = 1'b0;
                  end
               endcase
            end
            dda_pkg::MODE_WRITE: begin
               case (address)
                  dda_pkg::REG_TIMER_LO: begin
                     treload_in[7:0] = write_data;
                     flags_in[dda_pkg::FLAG_TIMER] = 1'b0;
                  end
                  dda_pkg::REG_TIMER_HI: begin
                     treload_in[15:8] = write_data;
                     flags_in[dda_pkg::FLAG_TIMER] = 1'b0;
                  end
                  dda_pkg::REG_TIMER_CTL: begin
                     tmode_in  = write_data[1:0];
                     tcount_in = treload_ff;
                     flags_in[dda_pkg::FLAG_TIMER] = 1'b0;
                  end
                  dda_pkg::REG_IO_EN: begin
                     io_en_in = write_data;
                  end
                  dda_pkg::REG_WR_DATA: begin
                     if (present_ff && !dctl_ff[2] && io_en_ff[0] &&
                         ptr_ff < dda_pkg::PTR_WRITE_LIMIT) begin
                        if (skip_ff != 2'd0) begin
                           skip_in = skip_ff - 2'd1;
                        end else if (ptr_ff >= 16'd2) begin
                           mem_ctl.wr_en = side_ok;
                           mem_addr      = wr_full[AW-1:0];
                        end
                     end
                  end
                  dda_pkg::REG_DRIVE_CTL: begin
                     flags_in[dda_pkg::FLAG_DISK] = 1'b0;
                     mirror_in = write_data[3];
                     if (present_ff) begin
                        // leaving transfer mode with bit 4 clear steps the head back
                        if (!write_data[6] && dctl_ff[6] && !write_data[4]) begin
                           ptr_in   = (ptr_ff >= 16'd2) ? ptr_back : 16'd0;
                           delay_in = dda_pkg::DELAY_LONG;
                        end
                        if (!write_data[2]) begin
                           skip_in = 2'd2;
                        end
                        if (write_data[1]) begin
                           ptr_in   = 16'd0;
                           delay_in = dda_pkg::DELAY_LONG;
                        end
                        if (write_data[6]) begin
                           delay_in = dda_pkg::DELAY_LONG;
                        end
                        dctl_in = write_data;
                     end
                  end
                  default: begin
                     dctl_in = dctl_ff;
                  end
               endcase
            end
            dda_pkg::MODE_LOAD: begin
               mem_ctl.wr_en = load_ok;
               mem_addr      = ld_full[AW-1:0];
            end
            default: begin
               dctl_in = dctl_ff;
            end
         endcase
      end

      info.irq    = (flags_in != 2'b00);
      info.mirror = mirror_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= 1'b0;
         side_ff    <= 2'd0;
         tcount_ff  <= 16'd0;
         treload_ff <= 16'd0;
         tmode_ff   <= 2'd0;
         io_en_ff   <= 8'd0;
         dctl_ff    <= 8'd0;
         flags_ff   <= 2'd0;
         ptr_ff     <= 16'd0;
         skip_ff    <= 2'd0;
         delay_ff   <= 8'd0;
         mirror_ff  <= 1'b0;
      end else begin
         if (csr_we && csr_index == dda_pkg::CSR_DISK_PRESENT) begin
            present_ff <= csr_wdata[0];
         end
         if (csr_we && csr_index == dda_pkg::CSR_DISK_SIDE) begin
            side_ff <= csr_wdata;
         end
         tcount_ff  <= tcount_in;
         treload_ff <= treload_in;
         tmode_ff   <= tmode_in;
         io_en_ff   <= io_en_in;
         dctl_ff    <= dctl_in;
         flags_ff   <= flags_in;
         ptr_ff     <= ptr_in;
         skip_ff    <= skip_in;
         delay_ff   <= delay_in;
         mirror_ff  <= mirror_in;
      end
   end

endmodule

### design/dda_resp.sv
module dda_resp (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  dda_pkg::stage_info_type info,
   input  logic [7:0]              mem_rdata,
   output logic                    ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              read_data,
   output logic                    handled,
   output logic                    irq_line,
   output logic                    mirroring
);

   logic                    s1_valid_ff;
   dda_pkg::stage_info_type s1_info_ff;
   logic                    out_valid_ff;
   logic [7:0]              out_data_ff;
   logic                    out_handled_ff;
   logic                    out_irq_ff;
   logic                    out_mirror_ff;
   logic [7:0]              last_byte_ff;
   logic [7:0]              s1_data;
   logic                    advance;

   // the memory read data stays put while stage one is stalled
   assign advance = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign ready   = !s1_valid_ff || advance;

   always_comb begin
      case (s1_info_ff.sel)
         dda_pkg::RD_DISK: s1_data = s1_info_ff.side_ok ? mem_rdata : 8'd0;
         dda_pkg::RD_LAST: s1_data = last_byte_ff;
         default:          s1_data = s1_info_ff.imm;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         last_byte_ff <= 8'd0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (advance && s1_info_ff.sel == dda_pkg::RD_DISK) begin
            last_byte_ff <= s1_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= info;
      end
      if (advance) begin
         out_data_ff    <= s1_data;
         out_handled_ff <= s1_info_ff.handled;
         out_irq_ff     <= s1_info_ff.irq;
         out_mirror_ff  <= s1_info_ff.mirror;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign read_data = out_data_ff;
   assign handled   = out_handled_ff;
   assign irq_line  = out_irq_ff;
   assign mirroring = out_mirror_ff;

endmodule

### design/disk_drive_adapter_with_timer_irq_top.sv
// Disk drive adapter with a reloadable interval timer. Each request is a CPU
// tick, a register read, a register write or an image load byte; each gives
// one response. One request is taken every clock while responses drain; a
// response goes from stage one (image memory read) to the output register.
// All small state sits in flops and is updated when a request is taken, but
// for the configuration bits, set by configuration writes. The disk image
// lives in one single-port synchronous RAM (DISK_SIDES x 64 KiB) that is read
// only by data register reads and written by data register writes and loads,
// so there is never more than one access per cycle. The image has no reset
// and must be loaded before it is read. Configuration writes are taken at
// any time but must only come while no request is in flight.
module disk_drive_adapter_with_timer_irq_top #(
   parameter int DISK_SIDES = dda_pkg::DISK_SIDES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] mode, [13:2] address, [21:14] write_data, [39:22] image_index
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_data, [8] handled, [9] irq_line, [10] mirroring, rest zero
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [1:0]  csr_wdata
);

   localparam int AW = $clog2(DISK_SIDES) + dda_pkg::SIDE_BITS;

   logic                    accept;
   dda_pkg::mem_ctl_type    mem_ctl;
   logic [AW-1:0]           mem_addr;
   logic [7:0]              mem_wdata;
   logic [7:0]              mem_rdata;
   dda_pkg::stage_info_type info;
   logic [7:0]              read_data;
   logic                    handled;
   logic                    irq_line;
   logic                    mirroring;

   assign accept = req_tvalid && req_tready;

   dda_ctrl #(
      .DISK_SIDES (DISK_SIDES),
      .AW         (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .mode        (req_tdata[1:0]),
      .address     (req_tdata[13:2]),
      .write_data  (req_tdata[21:14]),
      .image_index (req_tdata[39:22]),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mem_ctl     (mem_ctl),
      .mem_addr    (mem_addr),
      .mem_wdata   (mem_wdata),
      .info        (info)
   );

   dda_image_ram #(
      .DISK_SIDES (DISK_SIDES),
      .AW         (AW)
   ) u_ram (
      .clock     (clock),
      .mem_ctl   (mem_ctl),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   dda_resp u_resp (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .info      (info),
      .mem_rdata (mem_rdata),
      .ready     (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .read_data (read_data),
      .handled   (handled),
      .irq_line  (irq_line),
      .mirroring (mirroring)
   );

   assign rsp_tdata = {5'd0, mirroring, irq_line, handled, read_data};

endmodule
